// ===== src/imufsd_pkg.sv =====
`timescale 1ns / 1ps

package imufsd_pkg;

  localparam int FRAME_BYTES = 22;
  localparam int FILL_W      = $clog2(FRAME_BYTES + 1);

  localparam logic [7:0] SYNC_BYTE = 8'hFF;

  // Temperature: ((raw * 3555) >> 8) - 15643, in 1/256 degree C
  localparam logic [11:0] TEMP_SCALE  = 12'd3555;
  localparam int          TEMP_W      = 21;
  localparam logic [TEMP_W-1:0] TEMP_OFFSET = 21'd15643;

  localparam int COUNT_W   = 16;
  localparam int NUM_COUNT = 8;
  localparam int FIELD_W   = NUM_COUNT * COUNT_W + TEMP_W;
  localparam int TDATA_W   = ((FIELD_W + 7) / 8) * 8;

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FRAME_BYTES);

endpackage

// ===== src/imu_frame_sync_checksum_decode.sv =====
`timescale 1ns / 1ps

// Serial IMU deframer. Takes one received byte per cycle on s_* and keeps a
// 22-byte sliding window. Each time a full window starts with 0xFF and the
// mod-256 sum of bytes 1..20 equals byte 21, one decoded frame word goes out
// on m_*: eight big-endian signed 16-bit counts and a Q8 temperature. Every
// full window is checked, so overlapping windows can each produce a word.
// Throughput is one byte per cycle when not stalled. A decoded word is
// loaded into the m_* output register once the window register holds the
// completing byte and the output register is free. The input stalls only
// when a new frame is found while the held output word waits on a low m_tready.
module imu_frame_sync_checksum_decode (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,  // [7:0] rx_byte
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [15:0] roll_counts, [31:16] pitch_counts, [47:32] roll_rate_counts,
  // [63:48] pitch_rate_counts, [79:64] yaw_rate_counts,
  // [95:80] accel_x_counts, [111:96] accel_y_counts,
  // [127:112] accel_z_counts, [148:128] temperature_q8, rest zero
  output logic [imufsd_pkg::TDATA_W-1:0]  m_tdata
);

  import imufsd_pkg::*;

  logic [7:0]        win [FRAME_BYTES];
  logic [FILL_W-1:0] fill;
  logic              pend;   // window holds a byte not yet checked

  logic              s_acc;
  logic              out_free;
  logic              hit;
  logic              load_out;

  logic [7:0]        sum_l1 [10];
  logic [7:0]        sum_l2 [5];
  logic [7:0]        csum;

  logic [15:0]       temp_raw;
  logic [27:0]       temp_prod;
  logic [TEMP_W-1:0] temp_q8;
  logic [TDATA_W-1:0] data_next;

  // checksum over bytes 1..20 as a small adder tree
  always_comb begin
    for (int i = 0; i < 10; i++) begin
      sum_l1[i] = win[1 + 2 * i] + win[2 + 2 * i];
    end
    for (int i = 0; i < 5; i++) begin
      sum_l2[i] = sum_l1[2 * i] + sum_l1[2 * i + 1];
    end
    csum = sum_l2[0] + sum_l2[1] + sum_l2[2] + sum_l2[3] + sum_l2[4];
  end

  assign temp_raw  = {win[17], win[18]};
  assign temp_prod = temp_raw * TEMP_SCALE;
  assign temp_q8   = {1'b0, temp_prod[27:8]} - TEMP_OFFSET;

  always_comb begin
    data_next = '0;
    for (int i = 0; i < NUM_COUNT; i++) begin
      data_next[i * COUNT_W +: COUNT_W] = {win[1 + 2 * i], win[2 + 2 * i]};
    end
    data_next[NUM_COUNT * COUNT_W +: TEMP_W] = temp_q8;
  end

  assign hit      = pend && (fill == FILL_FULL) && (win[0] == SYNC_BYTE)
                    && (csum == win[FRAME_BYTES - 1]);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !hit || out_free;
  assign s_acc    = s_tvalid && s_tready;
  assign load_out = hit && out_free;

  always_ff @(posedge clk) begin
    if (s_acc) begin
      for (int i = 0; i < FRAME_BYTES - 1; i++) begin
        win[i] <= win[i + 1];
      end
      win[FRAME_BYTES - 1] <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      pend <= 1'b0;
    end else begin
      if (s_acc && fill != FILL_FULL) begin
        fill <= fill + 1'b1;
      end
      if (s_acc) begin
        pend <= 1'b1;
      end else if (!hit || out_free) begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= data_next;
    end
  end

endmodule

// ===== src/imufsd_checker.sv =====
`timescale 1ns / 1ps

module imufsd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [imufsd_pkg::TDATA_W-1:0] m_tdata
);

  import imufsd_pkg::*;

  logic [FILL_W-1:0] seen;   // bytes taken since reset, saturating

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (s_tvalid && s_tready && seen != FILL_FULL) begin
      seen <= seen + 1'b1;
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("held output word changed or dropped");

  a_no_early: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> seen == FILL_FULL)
    else $error("frame word before a full window of bytes");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled while output side is free");

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(m_tdata[NUM_COUNT * COUNT_W +: TEMP_W])
                 >= -$signed({1'b0, TEMP_OFFSET}))
    else $error("temperature below conversion floor");

endmodule

bind imu_frame_sync_checksum_decode imufsd_checker u_imufsd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import imufsd_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int RAND_BYTES   = 550;

  // all-extremes frame: roll max, pitch min, roll rate -1, temperature raw 0xFFFF
  localparam logic [TDATA_W-1:0] EXT_FRAME = TDATA_W'({21'd894423,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'hFFFF, 16'h8000, 16'h7FFF});

  typedef struct {
    logic [7:0]         rx;
    bit                 typed;
    logic [TDATA_W-1:0] word;
  } dir_row_t;

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [7:0]         s_tdata;
  logic               m_tvalid;
  logic               m_tready;
  logic [TDATA_W-1:0] m_tdata;

  imu_frame_sync_checksum_decode dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  // predictor state: sliding byte window and saturating fill count
  logic [7:0]         rx_window[FRAME_BYTES] = '{default: 8'h00};
  int unsigned        rx_fill = 0;
  logic [TDATA_W-1:0] decoded_q[$];

  int  errors       = 0;
  int  mismatches   = 0;
  int  bytes_sent   = 0;
  int  cycles       = 0;
  bit  tx_calm      = 0;
  bit  rx_calm      = 0;

  string field_names[9] = '{"roll_counts", "pitch_counts", "roll_rate_counts",
      "pitch_rate_counts", "yaw_rate_counts", "accel_x_counts", "accel_y_counts",
      "accel_z_counts", "temperature_q8"};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb failed");
      $finish;
    end
  end

  // Shift one byte into the window; returns 1 with the decoded word when the
  // full window is a synced frame with a matching checksum.
  function automatic bit imu_decode(input logic [7:0] rx,
                                    output logic [TDATA_W-1:0] word);
    logic [7:0]  sum;
    logic [31:0] raw, temp;
    for (int i = 0; i < FRAME_BYTES - 1; i++) rx_window[i] = rx_window[i + 1];
    rx_window[FRAME_BYTES - 1] = rx;
    if (rx_fill < FRAME_BYTES) rx_fill++;
    word = '0;
    if (rx_fill < FRAME_BYTES || rx_window[0] != SYNC_BYTE) return 1'b0;
    sum = 8'h00;
    for (int i = 1; i <= 20; i++) sum = sum + rx_window[i];
    if (sum != rx_window[21]) return 1'b0;
    for (int i = 0; i < 8; i++) word[16*i +: 16] = {rx_window[1 + 2*i], rx_window[2 + 2*i]};
    raw  = {16'h0000, rx_window[17], rx_window[18]};
    temp = ((raw * 32'd3555) >> 8) - 32'd15643;
    word[128 +: 21] = temp[20:0];
    return 1'b1;
  endfunction

  function automatic void flag_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    errors++;
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h got %h", what, want, got);
  endfunction

  task automatic send_byte(input logic [7:0] rx, input bit typed,
                           input logic [TDATA_W-1:0] typed_word);
    int                 gap;
    bit                 hit;
    logic [TDATA_W-1:0] word;
    if ($urandom_range(0, 15) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = rx;
    do @(posedge clk); while (!s_tready);
    hit = imu_decode(rx, word);
    if (typed) decoded_q.push_back(typed_word);
    else if (hit) decoded_q.push_back(word);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Builds and sends one frame with biased payload; a bad one gets a wrong sync
  // byte or checksum. A chained frame carries 0xFF in its first payload byte
  // and, if good, is followed by a byte making the window shifted by one valid.
  task automatic send_frame(input bit good, input bit chained);
    logic [7:0] fr[FRAME_BYTES];
    logic [7:0] sum;
    fr[0] = SYNC_BYTE;
    for (int i = 1; i <= 20; i++) begin
      case ($urandom_range(0, 7))
        0: fr[i] = 8'h00;
        1: fr[i] = 8'hFF;
        2: fr[i] = 8'h7F;
        3: fr[i] = 8'h80;
        default: fr[i] = 8'($urandom);
      endcase
    end
    if (chained) fr[1] = SYNC_BYTE;
    sum = 8'h00;
    for (int i = 1; i <= 20; i++) sum = sum + fr[i];
    fr[21] = sum;
    if (!good) begin
      if ($urandom_range(0, 1) == 1) fr[0] = 8'($urandom_range(0, 254));
      else fr[21] = fr[21] ^ 8'($urandom_range(1, 255));
    end
    for (int i = 0; i < FRAME_BYTES; i++) send_byte(fr[i], 1'b0, '0);
    if (chained && good) begin
      sum = 8'h00;
      for (int i = 2; i <= 21; i++) sum = sum + fr[i];
      send_byte(sum, 1'b0, '0);
    end
  endtask

  initial begin
    dir_row_t dir_rows[25];
    int       kind;
    dir_rows = '{
      '{8'hFF, 0, '0},
      '{8'h7F, 0, '0}, '{8'hFF, 0, '0},          // roll
      '{8'h80, 0, '0}, '{8'h00, 0, '0},          // pitch
      '{8'hFF, 0, '0}, '{8'hFF, 0, '0},          // roll rate
      '{8'h00, 0, '0}, '{8'h00, 0, '0},
      '{8'h00, 0, '0}, '{8'h00, 0, '0},
      '{8'h00, 0, '0}, '{8'h00, 0, '0},
      '{8'h00, 0, '0}, '{8'h00, 0, '0},
      '{8'h00, 0, '0}, '{8'h00, 0, '0},
      '{8'hFF, 0, '0}, '{8'hFF, 0, '0},          // temperature raw
      '{8'h00, 0, '0}, '{8'h00, 0, '0},
      '{8'hFA, 1, EXT_FRAME},                    // checksum completes first window
      '{8'hFF, 0, '0}, '{8'h00, 0, '0}, '{8'h55, 0, '0}
    };
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].word);

    while (bytes_sent < RAND_BYTES) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) send_frame(1'b1, $urandom_range(0, 3) == 0);
      else if (kind == 7) send_frame(1'b0, 1'b0);
      else begin
        repeat ($urandom_range(1, 5))
          send_byte(($urandom_range(0, 3) == 0) ? SYNC_BYTE : 8'($urandom), 1'b0, '0);
      end
    end
    s_tvalid = 1'b0;

    while (decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (decoded_q.size() != 0) errors++;

    if (errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

  // output side: random stalls, field-by-field compare against oldest expected word
  initial begin
    int                 gap;
    logic [TDATA_W-1:0] want, got;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
      gap = rx_calm ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
        m_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got = m_tdata;
      if (decoded_q.size() == 0) begin
        errors++;
        if (mismatches < 10) $display("unexpected word %h", got);
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (i < 8) begin
            if (got[16*i +: 16] !== want[16*i +: 16])
              flag_mismatch(field_names[i], 32'(want[16*i +: 16]), 32'(got[16*i +: 16]));
          end else if (got[128 +: 21] !== want[128 +: 21]) begin
            flag_mismatch(field_names[i], 32'(want[128 +: 21]), 32'(got[128 +: 21]));
          end
        end
        if ((got >> FIELD_W) !== '0)
          flag_mismatch("padding", 32'h0, 32'(got >> FIELD_W));
      end
      @(negedge clk);
    end
  end

endmodule

// ===== sim.f =====
src/imufsd_pkg.sv
src/imu_frame_sync_checksum_decode.sv
src/imufsd_checker.sv
tb/tb.sv
